### rtl/core/pfc_pkg.sv
package pfc_pkg;

  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef logic [3:0] fmt_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [PIXEL_W-1:0] pixel_t;

  localparam fmt_t FMT_NONE       = 4'd0;
  localparam fmt_t FMT_ALPHA      = 4'd1;
  localparam fmt_t FMT_RGB        = 4'd2;
  localparam fmt_t FMT_RGBA       = 4'd3;
  localparam fmt_t FMT_ARGB       = 4'd4;
  localparam fmt_t FMT_RGB555     = 4'd5;
  localparam fmt_t FMT_RGB565     = 4'd6;
  localparam fmt_t FMT_LUM        = 4'd7;
  localparam fmt_t FMT_LUM_ALPHA  = 4'd8;
  localparam fmt_t FMT_COMPRESSED = 4'd9;

  localparam logic REG_SOURCE_FORMAT = 1'b0;
  localparam logic REG_TARGET_FORMAT = 1'b1;

  // 683 / 2048 approximates one third closely enough for sums up to 765.
  localparam logic [9:0] DIV3_RECIP = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  typedef struct packed {
    fmt_t source_format;
    fmt_t target_format;
  } fmt_cfg_t;

  function automatic count_t pass_bytes(fmt_t f);
    count_t n;
    case (f) inside
      FMT_ALPHA, FMT_LUM: n = 3'd1;
      FMT_RGB: n = 3'd3;
      FMT_RGBA, FMT_ARGB: n = 3'd4;
      FMT_RGB555, FMT_RGB565, FMT_LUM_ALPHA: n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic pixel_t byte_mask(count_t n);
    pixel_t m;
    case (n)
      3'd0: m = 32'h0000_0000;
      3'd1: m = 32'h0000_00FF;
      3'd2: m = 32'h0000_FFFF;
      3'd3: m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/pfc_if.sv
interface pfc_in_if;
  logic                         valid;
  logic                         ready;
  logic [pfc_pkg::PIXEL_W-1:0]  source_pixel;
  logic                         end_of_image;

  modport source (output valid, output source_pixel, output end_of_image, input ready);
  modport sink (input valid, input source_pixel, input end_of_image, output ready);
endinterface

interface pfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [pfc_pkg::PIXEL_W-1:0]  target_pixel;
  logic [pfc_pkg::COUNT_W-1:0]  target_byte_count;
  logic                         end_of_image_out;

  modport source (output valid, output target_pixel, output target_byte_count,
                  output end_of_image_out, input ready);
  modport sink (input valid, input target_pixel, input target_byte_count,
                input end_of_image_out, output ready);
endinterface

### rtl/core/pfc_regs.sv
module pfc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfc_pkg::PADDR_W-1:0] paddr,
  input  logic [pfc_pkg::PDATA_W-1:0] pwdata,
  output logic [pfc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output pfc_pkg::fmt_cfg_t           cfg
);
  import pfc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_format <= FMT_NONE;
      cfg.target_format <= FMT_NONE;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SOURCE_FORMAT: cfg.source_format <= pwdata[3:0];
        REG_TARGET_FORMAT: cfg.target_format <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SOURCE_FORMAT: prdata = {{(PDATA_W-4){1'b0}}, cfg.source_format};
      REG_TARGET_FORMAT: prdata = {{(PDATA_W-4){1'b0}}, cfg.target_format};
      default: prdata = '0;
    endcase
  end

endmodule

### rtl/core/pfc_convert.sv
module pfc_convert (
  input  pfc_pkg::fmt_cfg_t  cfg,
  input  pfc_pkg::pixel_t    src,
  output pfc_pkg::pixel_t    dst,
  output pfc_pkg::count_t    count
);
  import pfc_pkg::*;

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] w;
  logic [7:0]  ch_r, ch_g, ch_b, ch_a;
  logic [9:0]  lum_sum;
  logic [19:0] lum_prod;
  logic [7:0]  lum;
  pixel_t      packed_px;
  count_t      packed_count;
  count_t      pass_count;

  assign b0 = src[7:0];
  assign b1 = src[15:8];
  assign b2 = src[23:16];
  assign b3 = src[31:24];
  assign w  = src[15:0];

  always_comb begin
    ch_r = 8'h00;
    ch_g = 8'h00;
    ch_b = 8'h00;
    ch_a = 8'h00;
    case (cfg.source_format)
      FMT_RGBA: begin
        ch_r = b0; ch_g = b1; ch_b = b2; ch_a = b3;
      end
      FMT_ARGB: begin
        ch_g = b0; ch_b = b1; ch_a = b2; ch_r = b3;
      end
      FMT_RGB: begin
        ch_r = b0; ch_g = b1; ch_b = b2; ch_a = 8'hFF;
      end
      FMT_RGB555: begin
        ch_r = {w[14:10], 3'b000};
        ch_g = {w[9:5], 3'b000};
        ch_b = {w[4:0], 3'b000};
        ch_a = 8'hFF;
      end
      FMT_RGB565: begin
        ch_r = {w[15:11], 3'b000};
        ch_g = {w[10:5], 2'b00};
        ch_b = {w[4:0], 3'b000};
        ch_a = 8'hFF;
      end
      FMT_LUM: begin
        ch_r = b0; ch_g = b0; ch_b = b0; ch_a = 8'hFF;
      end
      FMT_ALPHA: ch_a = b0;
      default: ;
    endcase
  end

  assign lum_sum  = {2'b00, ch_r} + {2'b00, ch_g} + {2'b00, ch_b};
  assign lum_prod = lum_sum * DIV3_RECIP;
  assign lum      = lum_prod[DIV3_SHIFT+7:DIV3_SHIFT];

  always_comb begin
    packed_px    = '0;
    packed_count = 3'd0;
    case (cfg.target_format)
      FMT_RGBA: begin
        packed_px    = {ch_a, ch_b, ch_g, ch_r};
        packed_count = 3'd4;
      end
      FMT_ARGB: begin
        packed_px    = {ch_r, ch_a, ch_b, ch_g};
        packed_count = 3'd4;
      end
      FMT_RGB: begin
        packed_px    = {8'h00, ch_b, ch_g, ch_r};
        packed_count = 3'd3;
      end
      FMT_RGB555: begin
        packed_px    = {17'd0, ch_r[7:3], ch_g[7:3], ch_b[7:3]};
        packed_count = 3'd2;
      end
      FMT_RGB565: begin
        packed_px    = {16'd0, ch_r[7:3], ch_g[7:2], ch_b[7:3]};
        packed_count = 3'd2;
      end
      FMT_LUM: begin
        packed_px    = {24'd0, lum};
        packed_count = 3'd1;
      end
      FMT_ALPHA: begin
        packed_px    = {24'd0, ch_a};
        packed_count = 3'd1;
      end
      default: ;
    endcase
  end

  assign pass_count = pass_bytes(cfg.source_format);

  always_comb begin
    if (cfg.source_format == cfg.target_format) begin
      dst   = src & byte_mask(pass_count);
      count = pass_count;
    end else begin
      dst   = packed_px;
      count = packed_count;
    end
  end

endmodule

### rtl/core/pixel_format_converter_unit.sv
// Converts a stream of pixels from the source format to the target format, one
// pixel per transaction, with one result transaction for each input transaction.
// The block is a two-register pipeline: an input register, the unpack/repack
// logic (including the divide by three for luminance, done as a multiply by a
// reciprocal), and an output register. It sustains one pixel per clock while the
// output is not stalled. A pixel's result moves from the input register into the
// output register once the output register is empty or its result is taken.
// Both format registers reset to "none" and must only be written while no pixel
// is in flight.
module pixel_format_converter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfc_pkg::PADDR_W-1:0] paddr,
  input  logic [pfc_pkg::PDATA_W-1:0] pwdata,
  output logic [pfc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  pfc_in_if.sink                      pixel_in,
  pfc_out_if.source                   pixel_out
);
  import pfc_pkg::*;

  fmt_cfg_t cfg;
  logic     s1_valid;
  pixel_t   s1_pixel;
  logic     s1_eoi;
  logic     out_valid;
  pixel_t   out_pixel;
  count_t   out_count;
  logic     out_eoi;
  pixel_t   conv_pixel;
  count_t   conv_count;
  logic     adv_out;
  logic     adv_in;

  pfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfc_convert u_convert (
    .cfg   (cfg),
    .src   (s1_pixel),
    .dst   (conv_pixel),
    .count (conv_count)
  );

  assign adv_out = !out_valid || pixel_out.ready;
  assign adv_in  = !s1_valid || adv_out;

  assign pixel_in.ready = adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_in) begin
      s1_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && pixel_in.valid) begin
      s1_pixel <= pixel_in.source_pixel;
      s1_eoi   <= pixel_in.end_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      out_pixel <= conv_pixel;
      out_count <= conv_count;
      out_eoi   <= s1_eoi;
    end
  end

  assign pixel_out.valid             = out_valid;
  assign pixel_out.target_pixel      = out_pixel;
  assign pixel_out.target_byte_count = out_count;
  assign pixel_out.end_of_image_out  = out_eoi;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= 3'd4)
    else $error("byte count out of range");

  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_count <= 3'd2 |-> out_pixel[31:16] == 16'h0000)
    else $error("bytes beyond the count are not zero");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv_out |=> s1_valid && $stable(s1_pixel))
    else $error("stalled pixel lost from input register");

  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv_out |=> out_valid)
    else $error("pixel dropped between stages");

endmodule
